// File: design/ckbh_pkg.sv
// ----------------------------------------------------------------------------
// ckbh_pkg: shared types and constants
// Widths, request codes, the control structs between the front end and the
// histogram unit, and the prefix bucket function.
// ----------------------------------------------------------------------------
package ckbh_pkg;

  localparam int PREFIX_CHARS  = 4;
  localparam int MAX_MER_CHARS = 32;

  localparam int MER_W       = 2 * MAX_MER_CHARS;
  localparam int BUCKET_W    = 2 * PREFIX_CHARS;
  localparam int NUM_BUCKETS = 1 << BUCKET_W;
  localparam int COUNT_W     = 32;
  localparam int KMER_W      = 6;
  localparam int LEN_W       = $clog2(MAX_MER_CHARS + 1);
  localparam int POS_W       = 7;
  localparam int BASE_W      = 2;
  localparam int QUERY_W     = 8;
  localparam int LIST_DEPTH  = 5;
  localparam int LIST_CNT_W  = 3;

  localparam logic [KMER_W-1:0] KMER_RESET = KMER_W'(21);
  localparam logic [KMER_W-1:0] KMER_MIN   = KMER_W'(5);
  localparam logic [KMER_W-1:0] KMER_MAX   = KMER_W'(MAX_MER_CHARS + 1);
  localparam logic [POS_W-1:0]  POS_MAX    = POS_W'(64);

  // request codes
  localparam logic REQ_BASE  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef logic [MER_W-1:0]    mer_t;
  typedef logic [BUCKET_W-1:0] bucket_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [POS_W-1:0]    pos_t;

  localparam count_t COUNT_MAX = '1;

  // front end -> histogram unit
  typedef struct packed {
    logic    valid;  // one read (query) or read-modify-write (bump)
    logic    query;
    logic    zero;   // query outside the bucket range answers zero
    bucket_t addr;
  } hist_req_t;

  // histogram unit -> front end
  typedef struct packed {
    logic   busy;     // clearing pass after reset
    logic   q_valid;  // query data this cycle
    count_t count;
  } hist_rsp_t;

  // first PREFIX_CHARS bases of a mer, padded with A on the right if short
  function automatic bucket_t bucket_of(mer_t mer, len_t len);
    mer_t sh;
    if (len >= LEN_W'(PREFIX_CHARS)) begin
      sh = mer >> {len - LEN_W'(PREFIX_CHARS), 1'b0};
    end else begin
      sh = mer << {LEN_W'(PREFIX_CHARS) - len, 1'b0};
    end
    return sh[BUCKET_W-1:0];
  endfunction

  // k saturated into its legal range, minus one
  function automatic len_t mer_len(logic [KMER_W-1:0] k);
    logic [KMER_W-1:0] ks;
    ks = k;
    if (ks < KMER_MIN) ks = KMER_MIN;
    if (ks > KMER_MAX) ks = KMER_MAX;
    return LEN_W'(ks - KMER_W'(1));
  endfunction

endpackage

// File: design/ckbh_ram.sv
// ----------------------------------------------------------------------------
// ckbh_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read returns old data on a
// same-address write.
// ----------------------------------------------------------------------------
module ckbh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/ckbh_hist.sv
// ----------------------------------------------------------------------------
// ckbh_hist: bucket histogram unit
// Counter RAM with a clearing pass after reset, a two-stage saturating
// read-modify-write with write-to-read forwarding, and query reads.
// ----------------------------------------------------------------------------
module ckbh_hist (
  input  logic                clk,
  input  logic                rst_n,
  input  ckbh_pkg::hist_req_t req,
  output ckbh_pkg::hist_rsp_t rsp
);
  import ckbh_pkg::*;

  logic    clr_busy_r, clr_busy_nxt;
  bucket_t clr_addr_r, clr_addr_nxt;
  logic    w_valid_r, w_query_r, w_zero_r;
  bucket_t w_addr_r;
  logic    fwd_hit_r, fwd_hit_nxt;
  count_t  fwd_data_r;

  logic    we;
  bucket_t waddr;
  count_t  wdata, rdata, cur, inc;

  ckbh_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (req.valid),
    .raddr (req.addr),
    .rdata (rdata)
  );

  // write stage
  always_comb begin
    cur   = fwd_hit_r ? fwd_data_r : rdata;
    inc   = (cur == COUNT_MAX) ? cur : cur + COUNT_W'(1);
    we    = clr_busy_r || (w_valid_r && !w_query_r);
    waddr = clr_busy_r ? clr_addr_r : w_addr_r;
    wdata = clr_busy_r ? '0 : inc;
    // read issued now sees this write only through forwarding
    fwd_hit_nxt = req.valid && we && (waddr == req.addr);

    clr_addr_nxt = clr_addr_r + BUCKET_W'(1);
    clr_busy_nxt = clr_busy_r && (clr_addr_r != '1);

    rsp.busy    = clr_busy_r;
    rsp.q_valid = w_valid_r && w_query_r;
    rsp.count   = w_zero_r ? '0 : cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      w_valid_r  <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
      w_valid_r  <= req.valid;
      fwd_hit_r  <= fwd_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_query_r  <= req.query;
    w_zero_r   <= req.zero;
    w_addr_r   <= req.addr;
    fwd_data_r <= wdata;
  end

endmodule

// File: design/canonical_kmer_bucket_histogram_top.sv
// ----------------------------------------------------------------------------
// canonical_kmer_bucket_histogram_top: canonical (k-1)-mer prefix histogram
// Rolls a forward (k-1)-mer and its reverse complement over a stream of
// bases and counts prefix buckets of first, last and canonical middle mers
// in a 256-entry saturating counter RAM; queries read back one bucket.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in_     | input     | in_valid/in_stall  | req_type, base, last_base,
//          |           |                    | query_bucket
//  out_    | output    | out_valid/out_stall| bucket_count (queries only)
//  cfg_    | input     | cfg_wr_en          | cfg_wr_data = kmer_size
//
//  A base transaction is accepted (mer update) and then evaluated
//  (bucket select). Evaluation waits until the bump list has drained, one
//  counter update per cycle through the RAM read-modify-write, and read
//  ends can queue up to 5 bumps.
//  A query is taken once the bump list is empty and the output register is
//  free; its count passes the registered RAM read, then the output register.
//  After reset a clearing pass writes all 256 counters, during which
//  in_stall stays high. out_stall holds the output register and so stalls queries.
// ----------------------------------------------------------------------------
module canonical_kmer_bucket_histogram_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_wr_en,
  input  logic [ckbh_pkg::KMER_W-1:0]          cfg_wr_data,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_req_type,
  input  logic [ckbh_pkg::BASE_W-1:0]          in_base,
  input  logic                                 in_last_base,
  input  logic [ckbh_pkg::QUERY_W-1:0]         in_query_bucket,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ckbh_pkg::COUNT_W-1:0]         out_bucket_count
);
  import ckbh_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } state_t;

  // control state
  state_t   state_r, state_nxt;
  len_t     len_r, len_nxt;
  mer_t     fwd_r, fwd_nxt;
  mer_t     rc_r, rc_nxt;
  pos_t     pos_r, pos_nxt;
  bucket_t  first_fwd_r, first_fwd_nxt;
  bucket_t  first_rc_r, first_rc_nxt;
  bucket_t  pend_r, pend_nxt;
  logic [LIST_CNT_W-1:0] list_cnt_r, list_cnt_nxt;
  logic     out_valid_r, out_valid_nxt;

  // payload
  bucket_t  list_r   [LIST_DEPTH];
  bucket_t  list_nxt [LIST_DEPTH];
  pos_t     evp_r, evp_nxt;        // position before the base under evaluation
  logic     evlast_r, evlast_nxt;
  count_t   out_count_r, out_count_nxt;

  hist_req_t hist_req;
  hist_rsp_t hist_rsp;

  logic     in_fire;
  mer_t     char_mask, rc_ins, fwd_new, rc_new;
  bucket_t  bf, br, canon, q_addr;
  logic     q_oob;
  pos_t     plen;

  ckbh_hist u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hist_req),
    .rsp   (hist_rsp)
  );

  // queries wait for earlier bumps and a free output slot
  assign in_stall = hist_rsp.busy || (state_r != ST_IDLE) ||
                    ((in_req_type == REQ_QUERY) &&
                     ((list_cnt_r != '0) || out_valid_r || hist_rsp.q_valid));
  assign in_fire  = in_valid && !in_stall;

  assign out_valid        = out_valid_r;
  assign out_bucket_count = out_count_r;

  always_comb begin
    // mer shift-in, masked to len characters
    for (int i = 0; i < MAX_MER_CHARS; i++) begin
      char_mask[2*i +: 2] = (LEN_W'(i) < len_r) ? 2'b11 : 2'b00;
      rc_ins[2*i +: 2]    = (LEN_W'(i) == len_r - LEN_W'(1)) ? ~in_base : 2'b00;
    end
    fwd_new = ({fwd_r[MER_W-3:0], in_base}) & char_mask;
    rc_new  = ((rc_r >> 2) | rc_ins) & char_mask;

    // buckets of the mers left by the accepted base
    bf    = bucket_of(fwd_r, len_r);
    br    = bucket_of(rc_r, len_r);
    canon = (fwd_r > rc_r) ? br : bf;
    plen  = POS_W'(len_r);

    // query address; indexes past the bucket range read as zero
    for (int i = 0; i < BUCKET_W; i++) begin
      q_addr[i] = (i < QUERY_W) ? in_query_bucket[i] : 1'b0;
    end
    q_oob = (BUCKET_W < QUERY_W) && ((in_query_bucket >> BUCKET_W) != '0);

    state_nxt     = state_r;
    len_nxt       = len_r;
    fwd_nxt       = fwd_r;
    rc_nxt        = rc_r;
    pos_nxt       = pos_r;
    first_fwd_nxt = first_fwd_r;
    first_rc_nxt  = first_rc_r;
    pend_nxt      = pend_r;
    list_cnt_nxt  = list_cnt_r;
    list_nxt      = list_r;
    evp_nxt       = evp_r;
    evlast_nxt    = evlast_r;
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    hist_req      = '0;

    if (cfg_wr_en) begin
      len_nxt = mer_len(cfg_wr_data);
    end

    // drain one bump per cycle while the histogram unit is not clearing
    if ((list_cnt_r != '0) && !hist_rsp.busy) begin
      hist_req.valid = 1'b1;
      hist_req.addr  = list_r[0];
      for (int i = 0; i < LIST_DEPTH - 1; i++) begin
        list_nxt[i] = list_r[i+1];
      end
      list_cnt_nxt = list_cnt_r - LIST_CNT_W'(1);
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_req_type == REQ_BASE) begin
            fwd_nxt    = fwd_new;
            rc_nxt     = rc_new;
            evp_nxt    = pos_r;
            evlast_nxt = in_last_base;
            if (in_last_base) begin
              pos_nxt = '0;
            end else if (pos_r < POS_MAX) begin
              pos_nxt = pos_r + POS_W'(1);
            end
            state_nxt = ST_EVAL;
          end else begin
            hist_req.valid = 1'b1;
            hist_req.query = 1'b1;
            hist_req.zero  = q_oob;
            hist_req.addr  = q_addr;
          end
        end
      end
      ST_EVAL: begin
        if (list_cnt_r == '0) begin
          if (evp_r == plen - POS_W'(1)) begin
            first_fwd_nxt = bf;
            first_rc_nxt  = br;
          end else if (evp_r == plen) begin
            if (!evlast_r) pend_nxt = canon;
          end else if (evp_r > plen) begin
            // list order: pending, then last mer's two strands on a last base, then first
            // mer's two strands when this is the second middle base
            list_nxt[0] = pend_r;
            if (evlast_r) begin
              list_nxt[1] = bf;
              list_nxt[2] = br;
              list_nxt[3] = first_fwd_r;
              list_nxt[4] = first_rc_r;
              list_cnt_nxt = (evp_r == plen + POS_W'(1)) ? LIST_CNT_W'(5)
                                                          : LIST_CNT_W'(3);
            end else begin
              pend_nxt    = canon;
              list_nxt[1] = first_fwd_r;
              list_nxt[2] = first_rc_r;
              list_cnt_nxt = (evp_r == plen + POS_W'(1)) ? LIST_CNT_W'(3)
                                                          : LIST_CNT_W'(1);
            end
          end
          if (evlast_r) begin
            fwd_nxt = '0;
            rc_nxt  = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // output register
    if (hist_rsp.q_valid) begin
      out_valid_nxt = 1'b1;
      out_count_nxt = hist_rsp.count;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= mer_len(KMER_RESET);
      fwd_r       <= '0;
      rc_r        <= '0;
      pos_r       <= '0;
      first_fwd_r <= '0;
      first_rc_r  <= '0;
      pend_r      <= '0;
      list_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      out_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      fwd_r       <= fwd_nxt;
      rc_r        <= rc_nxt;
      pos_r       <= pos_nxt;
      first_fwd_r <= first_fwd_nxt;
      first_rc_r  <= first_rc_nxt;
      pend_r      <= pend_nxt;
      list_cnt_r  <= list_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      out_count_r <= out_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    list_r      <= list_nxt;
    evp_r       <= evp_nxt;
    evlast_r    <= evlast_nxt;
  end

endmodule
